FILE: design/shs_pkg.sv
package shs_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_BACK_OFF    = 2'd1;
    localparam logic [1:0] CFG_PAUSE       = 2'd2;

    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd160;
    localparam logic [19:0] BACK_OFF_RST    = 20'd50000;
    localparam logic [23:0] PAUSE_RST       = 24'd1000000;

    // Phase codes as reported on the result word
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_FAST   = 3'd1;
    localparam logic [2:0] PH_PAUSE1 = 3'd2;
    localparam logic [2:0] PH_BACK   = 3'd3;
    localparam logic [2:0] PH_SLOW   = 3'd4;
    localparam logic [2:0] PH_PAUSE2 = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FAST   = 7'b0000010,
        ST_PAUSE1 = 7'b0000100,
        ST_BACK   = 7'b0001000,
        ST_SLOW   = 7'b0010000,
        ST_PAUSE2 = 7'b0100000,
        ST_DONE   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic stall_level;
    } item_t;

    typedef struct packed {
        logic       step_out;
        logic       toward_home;
        logic       motor_enabled;
        logic [2:0] phase;
        logic       homed;
    } result_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            ST_FAST:   code = PH_FAST;
            ST_PAUSE1: code = PH_PAUSE1;
            ST_BACK:   code = PH_BACK;
            ST_SLOW:   code = PH_SLOW;
            ST_PAUSE2: code = PH_PAUSE2;
            ST_DONE:   code = PH_DONE;
            default:   code = PH_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: design/shs_in_if.sv
interface shs_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic stall_level;

    modport source (output valid, output start_req, output stall_level, input ready);
    modport sink (input valid, input start_req, input stall_level, output ready);
endinterface

FILE: design/shs_out_if.sv
interface shs_out_if;
    logic       valid;
    logic       ready;
    logic       step_out;
    logic       toward_home;
    logic       motor_enabled;
    logic [2:0] phase;
    logic       homed;

    modport source (output valid, output step_out, output toward_home,
                    output motor_enabled, output phase, output homed, input ready);
    modport sink (input valid, input step_out, input toward_home,
                  input motor_enabled, input phase, input homed, output ready);
endinterface

FILE: design/shs_in_reg.sv
module shs_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    shs_in_if.sink        src,
    input  logic          advance,
    output logic          item_valid,
    output shs_pkg::item_t item
);
    import shs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new word when empty or when the held one moves on this cycle
    assign src.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (src.valid && src.ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            item_reg.start_req   <= src.start_req;
            item_reg.stall_level <= src.stall_level;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: design/shs_core.sv
module shs_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_idx,
    input  logic [shs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               advance,
    input  shs_pkg::item_t                     item,
    output shs_pkg::result_t                   res
);
    import shs_pkg::*;

    logic [15:0] half_reg;
    logic [19:0] back_reg;
    logic [23:0] pause_reg;

    phase_t      phase_reg, phase_next;
    logic [23:0] tmr_reg, tmr_next;
    logic [19:0] step_cnt_reg, step_cnt_next;
    logic        step_lvl_reg, step_lvl_next;
    logic        stall_lat_reg, stall_lat_next;
    logic        last_lvl_reg, last_lvl_next;
    logic        abort_reg, abort_next;

    logic        do_pause1, do_backoff, do_slow, do_pause2, do_done;
    logic [16:0] hp;
    logic [23:0] tmr_inc;
    logic [19:0] cnt_inc;
    logic        motion;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= HALF_PERIOD_RST;
            back_reg  <= BACK_OFF_RST;
            pause_reg <= PAUSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_HALF_PERIOD: half_reg  <= cfg_wdata[15:0];
                CFG_BACK_OFF:    back_reg  <= cfg_wdata[19:0];
                CFG_PAUSE:       pause_reg <= cfg_wdata[23:0];
                default:         ;
            endcase
        end
    end

    assign tmr_inc = tmr_reg + 24'd1;
    assign cnt_inc = step_cnt_reg + 20'd1;

    always_comb
    begin
        // Zero half period runs as one tick; slow homing doubles it
        hp = (half_reg == 16'd0) ? 17'd1 : {1'b0, half_reg};
        if (phase_reg == ST_SLOW)
            hp = {hp[15:0], 1'b0};
    end

    always_comb
    begin
        phase_next     = phase_reg;
        tmr_next       = tmr_reg;
        step_cnt_next  = step_cnt_reg;
        step_lvl_next  = step_lvl_reg;
        stall_lat_next = stall_lat_reg | (item.stall_level & ~last_lvl_reg);
        last_lvl_next  = item.stall_level;
        abort_next     = abort_reg;
        do_pause1      = 1'b0;
        do_backoff     = 1'b0;
        do_slow        = 1'b0;
        do_pause2      = 1'b0;
        do_done        = 1'b0;

        unique case (phase_reg)
            ST_IDLE, ST_DONE:
            begin
                if (item.start_req)
                begin
                    abort_next    = 1'b0;
                    step_cnt_next = '0;
                    if (stall_lat_next)
                    begin
                        // stale stall: skip fast homing
                        stall_lat_next = 1'b0;
                        do_pause1      = 1'b1;
                    end
                    else
                    begin
                        phase_next    = ST_FAST;
                        tmr_next      = '0;
                        step_lvl_next = 1'b1;
                    end
                end
            end
            ST_FAST, ST_BACK, ST_SLOW:
            begin
                if (tmr_inc >= {7'd0, hp})
                begin
                    tmr_next = '0;
                    if (step_lvl_reg)
                        step_lvl_next = 1'b0;
                    else
                    begin
                        // end of step: test the stall latch
                        step_lvl_next = 1'b1;
                        if (phase_reg == ST_BACK)
                        begin
                            step_cnt_next = cnt_inc;
                            if (stall_lat_next)
                            begin
                                abort_next     = 1'b1;
                                stall_lat_next = 1'b0;
                                do_pause2      = 1'b1;
                            end
                            else if (cnt_inc >= back_reg)
                                do_slow = 1'b1;
                        end
                        else if (stall_lat_next)
                        begin
                            stall_lat_next = 1'b0;
                            if (phase_reg == ST_FAST)
                                do_pause1 = 1'b1;
                            else
                                do_pause2 = 1'b1;
                        end
                    end
                end
                else
                    tmr_next = tmr_inc;
            end
            ST_PAUSE1, ST_PAUSE2:
            begin
                tmr_next = tmr_inc;
                if (tmr_inc >= pause_reg)
                begin
                    if (phase_reg == ST_PAUSE1)
                        do_backoff = 1'b1;
                    else
                        do_done = 1'b1;
                end
            end
            default:
            begin
                phase_next    = ST_IDLE;
                tmr_next      = '0;
                step_lvl_next = 1'b0;
            end
        endcase

        // Phase entries, in order; a zero length chains into the next one
        if (do_pause1)
        begin
            phase_next    = ST_PAUSE1;
            tmr_next      = '0;
            step_lvl_next = 1'b0;
            if (pause_reg == 24'd0)
                do_backoff = 1'b1;
        end
        if (do_backoff)
        begin
            step_cnt_next = '0;
            if (back_reg == 20'd0)
                do_slow = 1'b1;
            else
            begin
                phase_next    = ST_BACK;
                tmr_next      = '0;
                step_lvl_next = 1'b1;
            end
        end
        if (do_slow)
        begin
            if (stall_lat_next)
            begin
                abort_next     = 1'b1;
                stall_lat_next = 1'b0;
                do_pause2      = 1'b1;
            end
            else
            begin
                phase_next    = ST_SLOW;
                tmr_next      = '0;
                step_lvl_next = 1'b1;
            end
        end
        if (do_pause2)
        begin
            phase_next    = ST_PAUSE2;
            tmr_next      = '0;
            step_lvl_next = 1'b0;
            if (pause_reg == 24'd0)
                do_done = 1'b1;
        end
        if (do_done)
        begin
            phase_next    = ST_DONE;
            tmr_next      = '0;
            step_lvl_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ST_IDLE;
            tmr_reg       <= '0;
            step_cnt_reg  <= '0;
            step_lvl_reg  <= 1'b0;
            stall_lat_reg <= 1'b0;
            last_lvl_reg  <= 1'b0;
            abort_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            tmr_reg       <= tmr_next;
            step_cnt_reg  <= step_cnt_next;
            step_lvl_reg  <= step_lvl_next;
            stall_lat_reg <= stall_lat_next;
            last_lvl_reg  <= last_lvl_next;
            abort_reg     <= abort_next;
        end
    end

    assign motion = (phase_next == ST_FAST) || (phase_next == ST_BACK) ||
                    (phase_next == ST_SLOW);

    always_comb
    begin
        res.step_out      = motion & step_lvl_next;
        res.motor_enabled = motion || (phase_next == ST_DONE);
        res.phase         = phase_code(phase_next);
        res.homed         = (phase_next == ST_DONE);
        unique case (phase_next)
            ST_FAST, ST_SLOW, ST_PAUSE1: res.toward_home = 1'b1;
            ST_PAUSE2, ST_DONE:          res.toward_home = ~abort_next;
            default:                     res.toward_home = 1'b0;
        endcase
    end

`ifndef SYNTH
    a_homed_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        res.homed |-> (res.motor_enabled && !res.step_out))
        else $error("homed without motor enabled or with step high");

    a_step_in_motion: assert property (@(posedge clk) disable iff (!rst_n)
        res.step_out |-> (res.phase == PH_FAST || res.phase == PH_BACK ||
                          res.phase == PH_SLOW))
        else $error("step pin high outside a motion phase");

    a_latch_from_edge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stall_lat_reg) |-> $past(advance && item.stall_level && !last_lvl_reg))
        else $error("stall latch set without a rising stall edge");
`endif

endmodule

FILE: design/shs_out_reg.sv
module shs_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    shs_out_if.source        dst,
    input  logic             load,
    input  shs_pkg::result_t res,
    output logic             space
);
    import shs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space = !valid_reg || dst.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (dst.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold the word until taken
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign dst.valid         = valid_reg;
    assign dst.step_out      = res_reg.step_out;
    assign dst.toward_home   = res_reg.toward_home;
    assign dst.motor_enabled = res_reg.motor_enabled;
    assign dst.phase         = res_reg.phase;
    assign dst.homed         = res_reg.homed;

endmodule

FILE: design/stall_homing_step_sequencer.sv
// Channel     | Dir | Payload
// item_in     | in  | start_req, stall_level (one timer tick per word)
// result_out  | out | step_out, toward_home, motor_enabled, phase, homed
// cfg_*       | in  | cfg_we, cfg_idx, cfg_wdata: half period, back-off steps, pause
//
// One word in per clock while the output is not stalled; each taken word is held in
// the input register and its result then in the result register.
// The sequencer state advances in the same cycle as the result register loads.
// Reset clears the sequencer to idle and loads the default register values.
// A stalled output holds its word; the input register still takes one more word.
module stall_homing_step_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    shs_in_if.sink                         item_in,
    shs_out_if.source                      result_out,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_idx,
    input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import shs_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t res;
    logic    space;
    logic    advance;

    assign advance = item_valid && space;

    shs_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    shs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .res       (res)
    );

    shs_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .dst   (result_out),
        .load  (advance),
        .res   (res),
        .space (space)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import shs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    shs_in_if  tick_if ();
    shs_out_if pin_if ();

    stall_homing_step_sequencer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (tick_if),
        .result_out (pin_if),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata)
    );

    // Sequencer copy: registers
    logic [15:0] cfg_half;
    logic [19:0] cfg_back;
    logic [23:0] cfg_pause;

    // Sequencer copy: state
    logic [2:0]  mdl_phase;
    logic [23:0] mdl_timer;
    logic [19:0] mdl_steps;
    logic        mdl_level;
    logic        mdl_latch;
    logic        mdl_last_stall;
    logic        mdl_aborted;

    result_t     pins_due[$];
    int unsigned mismatches;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          tick_hi;
    bit          stall_now;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic void go_motion(input logic [2:0] ph);
        mdl_phase = ph;
        mdl_timer = '0;
        mdl_level = 1'b1;
    endfunction

    function automatic void go_done();
        mdl_phase = PH_DONE;
        mdl_timer = '0;
        mdl_level = 1'b0;
    endfunction

    function automatic void go_pause2();
        mdl_phase = PH_PAUSE2;
        mdl_timer = '0;
        mdl_level = 1'b0;
        if (cfg_pause == '0)
            go_done();
    endfunction

    function automatic void go_slow();
        if (mdl_latch)
        begin
            mdl_aborted = 1'b1;
            mdl_latch = 1'b0;
            go_pause2();
        end
        else
            go_motion(PH_SLOW);
    endfunction

    function automatic void go_backoff();
        mdl_steps = '0;
        if (cfg_back == '0)
            go_slow();
        else
            go_motion(PH_BACK);
    endfunction

    function automatic void go_pause1();
        mdl_phase = PH_PAUSE1;
        mdl_timer = '0;
        mdl_level = 1'b0;
        if (cfg_pause == '0)
            go_backoff();
    endfunction

    // The latch is looked at here when a low half period ends, and also at start and slow entry
    function automatic void finish_step();
        if (mdl_phase == PH_FAST)
        begin
            if (mdl_latch)
            begin
                mdl_latch = 1'b0;
                go_pause1();
            end
        end
        else if (mdl_phase == PH_BACK)
        begin
            mdl_steps = mdl_steps + 1'b1;
            if (mdl_latch)
            begin
                mdl_aborted = 1'b1;
                mdl_latch = 1'b0;
                go_pause2();
            end
            else if (mdl_steps >= cfg_back)
                go_slow();
        end
        else if (mdl_latch)
        begin
            mdl_latch = 1'b0;
            go_pause2();
        end
    endfunction

    function automatic void advance_motion();
        int unsigned hp;
        hp = (cfg_half == '0) ? 1 : cfg_half;
        if (mdl_phase == PH_SLOW)
            hp = hp << 1;
        mdl_timer = mdl_timer + 1'b1;
        if (mdl_timer >= hp)
        begin
            mdl_timer = '0;
            if (mdl_level)
                mdl_level = 1'b0;
            else
            begin
                mdl_level = 1'b1;
                finish_step();
            end
        end
    endfunction

    function automatic result_t home_tick(input item_t it);
        result_t r;
        bit      moving;
        // Latch the edge before any end-of-step test in this tick
        if (it.stall_level && !mdl_last_stall)
            mdl_latch = 1'b1;
        mdl_last_stall = it.stall_level;

        case (mdl_phase)
            PH_IDLE, PH_DONE:
                if (it.start_req)
                begin
                    mdl_aborted = 1'b0;
                    mdl_steps = '0;
                    if (mdl_latch)
                    begin
                        mdl_latch = 1'b0;
                        go_pause1();
                    end
                    else
                        go_motion(PH_FAST);
                end
            PH_FAST, PH_BACK, PH_SLOW:
                advance_motion();
            PH_PAUSE1, PH_PAUSE2:
            begin
                mdl_timer = mdl_timer + 1'b1;
                if (mdl_timer >= cfg_pause)
                begin
                    if (mdl_phase == PH_PAUSE1)
                        go_backoff();
                    else
                        go_done();
                end
            end
            default:
            begin
                mdl_phase = PH_IDLE;
                mdl_timer = '0;
                mdl_level = 1'b0;
            end
        endcase

        moving = (mdl_phase == PH_FAST || mdl_phase == PH_BACK || mdl_phase == PH_SLOW);
        case (mdl_phase)
            PH_FAST, PH_SLOW, PH_PAUSE1: r.toward_home = 1'b1;
            PH_PAUSE2, PH_DONE:          r.toward_home = !mdl_aborted;
            default:                     r.toward_home = 1'b0;
        endcase
        r.step_out      = moving ? mdl_level : 1'b0;
        r.motor_enabled = moving || (mdl_phase == PH_DONE);
        r.phase         = mdl_phase;
        r.homed         = (mdl_phase == PH_DONE);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Take result words and hold ready low at random
    initial
    begin
        result_t want;
        pin_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pin_if.valid === 1'b1 && pin_if.ready === 1'b1)
            begin
                if (pins_due.size() == 0)
                begin
                    $display("%0t: expected no word, actual %0b/%0b/%0b/%0d/%0b",
                             $time, pin_if.step_out, pin_if.toward_home,
                             pin_if.motor_enabled, pin_if.phase, pin_if.homed);
                    mismatches++;
                end
                else
                begin
                    want = pins_due.pop_front();
                    check_field("step_out", 32'(want.step_out), 32'(pin_if.step_out));
                    check_field("toward_home", 32'(want.toward_home),
                                32'(pin_if.toward_home));
                    check_field("motor_enabled", 32'(want.motor_enabled),
                                32'(pin_if.motor_enabled));
                    check_field("phase", 32'(want.phase), 32'(pin_if.phase));
                    check_field("homed", 32'(want.homed), 32'(pin_if.homed));
                end
            end
            pin_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic drive_tick(input bit start, input bit stall);
        item_t it;
        it.start_req   = start;
        it.stall_level = stall;
        stall_now      = stall;
        tick_if.valid       <= 1'b1;
        tick_if.start_req   <= start;
        tick_if.stall_level <= stall;
        tick_hi = 1'b1;
        @(posedge clk);
        while (tick_if.ready !== 1'b1)
            @(posedge clk);
        pins_due.push_back(home_tick(it));
        while ($urandom_range(99) < tx_idle_pct)
        begin
            if (tick_hi)
            begin
                tick_if.valid       <= 1'b0;
                tick_if.start_req   <= 1'($urandom);
                tick_if.stall_level <= 1'($urandom);
                tick_hi = 1'b0;
            end
            @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding word
    task automatic settle();
        if (tick_hi)
        begin
            tick_if.valid <= 1'b0;
            tick_hi = 1'b0;
        end
        while (pins_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_HALF_PERIOD: cfg_half  = value[15:0];
            CFG_BACK_OFF:    cfg_back  = value[19:0];
            CFG_PAUSE:       cfg_pause = value[23:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reset registers in place; an edge in idle leaves the latch set
    task automatic test_idle_latch();
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b1);
    endtask

    // Stale latch skips fast homing; zero pause, back-off and half period
    task automatic test_stale_start();
        settle();
        write_reg(CFG_HALF_PERIOD, 24'd0);
        write_reg(CFG_BACK_OFF, 24'd0);
        write_reg(CFG_PAUSE, 24'd0);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
    endtask

    // Restart from done, start while busy, stall ending the last back-off step
    task automatic test_abort_and_restart();
        settle();
        write_reg(CFG_BACK_OFF, 24'd1);
        write_reg(CFG_PAUSE, 24'd1);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b1, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
    endtask

    // No back-off steps and a stall during the first pause: counts as abort
    task automatic test_zero_backoff_abort();
        settle();
        write_reg(CFG_BACK_OFF, 24'd0);
        write_reg(CFG_PAUSE, 24'd2);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b0);
    endtask

    // Largest register values, then shrink them to release each phase
    task automatic test_register_extremes();
        settle();
        write_reg(CFG_HALF_PERIOD, 24'd65535);
        write_reg(CFG_BACK_OFF, 24'd1048575);
        write_reg(CFG_PAUSE, 24'd16777215);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b1);
        settle();
        write_reg(CFG_HALF_PERIOD, 24'd0);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b0);
        settle();
        write_reg(CFG_PAUSE, 24'd1);
        drive_tick(1'b0, 1'b0);
        settle();
        write_reg(CFG_BACK_OFF, 24'd1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b0);
    endtask

    // Homing runs: small registers, usually a start up front, stall edges at a random rate
    task automatic test_random_homing(input int unsigned count);
        int unsigned sent;
        int unsigned run_len;
        int unsigned edge_odds;
        bit          start;
        bit          stall;
        sent = 0;
        while (sent < count)
        begin
            settle();
            write_reg(CFG_HALF_PERIOD, 24'(($urandom_range(9) == 0) ?
                      $urandom_range(4, 12) : $urandom_range(0, 3)));
            write_reg(CFG_BACK_OFF, 24'(($urandom_range(9) == 0) ?
                      $urandom_range(5, 10) : $urandom_range(0, 4)));
            write_reg(CFG_PAUSE, 24'(($urandom_range(9) == 0) ?
                      $urandom_range(6, 20) : $urandom_range(0, 5)));
            run_len   = $urandom_range(8, 40);
            edge_odds = $urandom_range(2, 10);
            stall     = stall_now;
            for (int unsigned i = 0; i < run_len; i++)
            begin
                if (i == 0)
                    start = ($urandom_range(9) != 0);
                else
                    start = ($urandom_range(29) == 0);
                if ($urandom_range(edge_odds - 1) == 0)
                    stall = ~stall;
                drive_tick(start, stall);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_HALF_PERIOD;
        cfg_wdata           <= '0;
        tick_if.valid       <= 1'b0;
        tick_if.start_req   <= 1'b0;
        tick_if.stall_level <= 1'b0;
        tick_hi     = 1'b0;
        stall_now   = 1'b0;
        mismatches  = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 80;

        cfg_half       = HALF_PERIOD_RST;
        cfg_back       = BACK_OFF_RST;
        cfg_pause      = PAUSE_RST;
        mdl_phase      = PH_IDLE;
        mdl_timer      = '0;
        mdl_steps      = '0;
        mdl_level      = 1'b0;
        mdl_latch      = 1'b0;
        mdl_last_stall = 1'b0;
        mdl_aborted    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_latch();
        test_stale_start();
        test_abort_and_restart();
        test_zero_backoff_abort();
        test_register_extremes();

        test_random_homing(310);
        settle();
        tx_idle_pct = 80;
        rx_idle_pct = 18;
        test_random_homing(310);
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_homing(310);

        settle();
        // Wait on for any stray word
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
